// ===== hw/rtl/scs1_pkg.sv =====
package scs1_pkg;

	typedef struct packed {
		logic e0;
		logic scroll;
		logic num;
		logic caps;
		logic alt;
		logic ctrl;
		logic shift;
	} flags_t;

	localparam logic [7:0] SC_PREFIX    = 8'hE0;
	localparam logic [7:0] SC_BREAK_BIT = 8'h80;
	localparam logic [7:0] SC_LOW_MASK  = 8'h7F;

	localparam logic [7:0] SC_CTRL_MAKE   = 8'h1D;
	localparam logic [7:0] SC_CTRL_EXT    = 8'h9D;
	localparam logic [7:0] SC_LSHIFT      = 8'h2A;
	localparam logic [7:0] SC_RSHIFT      = 8'h36;
	localparam logic [7:0] SC_ALT_MAKE    = 8'h38;
	localparam logic [7:0] SC_ALT_EXT     = 8'hB8;
	localparam logic [7:0] SC_CAPS_LOCK   = 8'h3A;
	localparam logic [7:0] SC_NUM_LOCK    = 8'h45;
	localparam logic [7:0] SC_SCROLL_LOCK = 8'h46;

	localparam logic [7:0] SC_KP_ENTER  = 8'h9C;
	localparam logic [7:0] SC_KP_DIVIDE = 8'hB5;
	localparam logic [7:0] SC_HOME      = 8'hC7;
	localparam logic [7:0] SC_END       = 8'hCF;
	localparam logic [7:0] SC_UP        = 8'hC8;
	localparam logic [7:0] SC_DOWN      = 8'hD0;
	localparam logic [7:0] SC_LEFT      = 8'hCB;
	localparam logic [7:0] SC_RIGHT     = 8'hCD;
	localparam logic [7:0] SC_PGUP      = 8'hC9;
	localparam logic [7:0] SC_PGDN      = 8'hD1;
	localparam logic [7:0] SC_INS       = 8'hD2;
	localparam logic [7:0] SC_DEL       = 8'hD3;

	localparam logic [7:0] KEY_NONE      = 8'h00;
	localparam logic [7:0] KEY_ENTER     = 8'h0A;
	localparam logic [7:0] KEY_SLASH     = 8'h2F;
	localparam logic [7:0] NAV_HOME      = 8'hE0;
	localparam logic [7:0] KEY_END       = 8'hE1;
	localparam logic [7:0] KEY_UP        = 8'hE2;
	localparam logic [7:0] KEY_DOWN      = 8'hE3;
	localparam logic [7:0] KEY_LEFT      = 8'hE4;
	localparam logic [7:0] KEY_RIGHT     = 8'hE5;
	localparam logic [7:0] NAV_PAGE_UP   = 8'hE6;
	localparam logic [7:0] NAV_PAGE_DOWN = 8'hE7;
	localparam logic [7:0] KEY_INS       = 8'hE8;
	localparam logic [7:0] KEY_DEL       = 8'hE9;

	localparam logic [7:0] CASE_FLIP = 8'h20;

	localparam logic [7:0] MAIN_ROM_END = 8'h58;
	localparam logic [7:0] CTRL_ROM_END = 8'h38;

	localparam logic [7:0] PLAIN_ROM [0:87] = '{
		8'h00, 8'h1B, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36,
		8'h37, 8'h38, 8'h39, 8'h30, 8'h2D, 8'h3D, 8'h08, 8'h09,
		8'h71, 8'h77, 8'h65, 8'h72, 8'h74, 8'h79, 8'h75, 8'h69,
		8'h6F, 8'h70, 8'h5B, 8'h5D, 8'h0A, 8'h00, 8'h61, 8'h73,
		8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B, 8'h6C, 8'h3B,
		8'h27, 8'h60, 8'h00, 8'h5C, 8'h7A, 8'h78, 8'h63, 8'h76,
		8'h62, 8'h6E, 8'h6D, 8'h2C, 8'h2E, 8'h2F, 8'h00, 8'h2A,
		8'h00, 8'h20, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
		8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h37,
		8'h38, 8'h39, 8'h2D, 8'h34, 8'h35, 8'h36, 8'h2B, 8'h31,
		8'h32, 8'h33, 8'h30, 8'h2E, 8'h00, 8'h00, 8'h00, 8'h00
	};

	localparam logic [7:0] SHIFT_ROM [0:87] = '{
		8'h00, 8'h1B, 8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5E,
		8'h26, 8'h2A, 8'h28, 8'h29, 8'h5F, 8'h2B, 8'h08, 8'h09,
		8'h51, 8'h57, 8'h45, 8'h52, 8'h54, 8'h59, 8'h55, 8'h49,
		8'h4F, 8'h50, 8'h7B, 8'h7D, 8'h0A, 8'h00, 8'h41, 8'h53,
		8'h44, 8'h46, 8'h47, 8'h48, 8'h4A, 8'h4B, 8'h4C, 8'h3A,
		8'h22, 8'h7E, 8'h00, 8'h7C, 8'h5A, 8'h58, 8'h43, 8'h56,
		8'h42, 8'h4E, 8'h4D, 8'h3C, 8'h3E, 8'h3F, 8'h00, 8'h2A,
		8'h00, 8'h20, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
		8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h37,
		8'h38, 8'h39, 8'h2D, 8'h34, 8'h35, 8'h36, 8'h2B, 8'h31,
		8'h32, 8'h33, 8'h30, 8'h2E, 8'h00, 8'h00, 8'h00, 8'h00
	};

	localparam logic [7:0] CTRL_ROM [0:55] = '{
		8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
		8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
		8'h11, 8'h17, 8'h05, 8'h12, 8'h14, 8'h19, 8'h15, 8'h09,
		8'h0F, 8'h10, 8'h00, 8'h00, 8'h0D, 8'h00, 8'h01, 8'h13,
		8'h04, 8'h06, 8'h07, 8'h08, 8'h0A, 8'h0B, 8'h0C, 8'h00,
		8'h00, 8'h00, 8'h00, 8'h1C, 8'h1A, 8'h18, 8'h03, 8'h16,
		8'h02, 8'h0E, 8'h0D, 8'h00, 8'h00, 8'hEF, 8'h00, 8'h00
	};

	function automatic flags_t hold_mask(input logic [7:0] code);
		flags_t m;
		m = '0;
		case (code)
			SC_CTRL_MAKE, SC_CTRL_EXT: m.ctrl = 1'b1;
			SC_LSHIFT, SC_RSHIFT: m.shift = 1'b1;
			SC_ALT_MAKE, SC_ALT_EXT: m.alt = 1'b1;
			default: m = '0;
		endcase
		return m;
	endfunction

	function automatic flags_t lock_mask(input logic [7:0] code);
		flags_t m;
		m = '0;
		case (code)
			SC_CAPS_LOCK: m.caps = 1'b1;
			SC_NUM_LOCK: m.num = 1'b1;
			SC_SCROLL_LOCK: m.scroll = 1'b1;
			default: m = '0;
		endcase
		return m;
	endfunction

	function automatic logic [7:0] lookup_char(input logic [7:0] code, input logic ctrl,
			input logic shift);
		logic [7:0] c;
		case (code)
			SC_KP_ENTER: c = KEY_ENTER;
			SC_KP_DIVIDE: c = KEY_SLASH;
			SC_HOME: c = NAV_HOME;
			SC_END: c = KEY_END;
			SC_UP: c = KEY_UP;
			SC_DOWN: c = KEY_DOWN;
			SC_LEFT: c = KEY_LEFT;
			SC_RIGHT: c = KEY_RIGHT;
			SC_PGUP: c = NAV_PAGE_UP;
			SC_PGDN: c = NAV_PAGE_DOWN;
			SC_INS: c = KEY_INS;
			SC_DEL: c = KEY_DEL;
			default: begin
				if (ctrl) begin
					c = (code < CTRL_ROM_END) ? CTRL_ROM[code[5:0]] : KEY_NONE;
				end else if (shift) begin
					c = (code < MAIN_ROM_END) ? SHIFT_ROM[code[6:0]] : KEY_NONE;
				end else begin
					c = (code < MAIN_ROM_END) ? PLAIN_ROM[code[6:0]] : KEY_NONE;
				end
			end
		endcase
		return c;
	endfunction

endpackage

// ===== hw/rtl/scs1_decode.sv =====
module scs1_decode
	import scs1_pkg::*;
(
	input  logic [7:0] scan_byte,
	input  flags_t     flags,
	output flags_t     next_flags,
	output logic [7:0] char_code
);

	logic [7:0] code;
	logic [7:0] raw_char;
	flags_t     made;

	always_comb begin
		made = flags;
		made.e0 = 1'b0;
		code = flags.e0 ? (scan_byte | SC_BREAK_BIT) : scan_byte;
		made = made | hold_mask(code);
		made = made ^ lock_mask(code);
		raw_char = lookup_char(code, made.ctrl, made.shift);

		if (scan_byte == SC_PREFIX) begin
			next_flags = flags;
			next_flags.e0 = 1'b1;
			char_code = KEY_NONE;
		end else if ((scan_byte & SC_BREAK_BIT) != 8'h00) begin
			code = flags.e0 ? scan_byte : (scan_byte & SC_LOW_MASK);
			next_flags = flags & ~hold_mask(code);
			next_flags.e0 = 1'b0;
			char_code = KEY_NONE;
		end else begin
			next_flags = made;
			char_code = raw_char;
			// Caps lock swaps the case of letters only.
			if (made.caps && (((raw_char >= 8'h61) && (raw_char <= 8'h7A)) ||
					((raw_char >= 8'h41) && (raw_char <= 8'h5A)))) begin
				char_code = raw_char ^ CASE_FLIP;
			end
		end
	end

endmodule

// ===== hw/rtl/scancode_set1_to_ascii.sv =====
// Channel  Direction  Handshake               Payload
// scan     in         scan_valid/scan_stall   scan_byte[7:0]
// char     out        char_valid/char_stall   char_code[7:0]
//
// One word is accepted per cycle while scan_stall is low, and every word gives exactly one char word.
// Each word passes through an input register, then the result register.
// The modifier flag register feeds back through the decoder, and that loop sets the rate.
// Reset (arst_n low, asynchronous) clears the flags and both valid bits.
// A stalled result holds while one more word waits in the input register.
module scancode_set1_to_ascii
	import scs1_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       scan_valid,
	output logic       scan_stall,
	input  logic [7:0] scan_byte,
	output logic       char_valid,
	input  logic       char_stall,
	output logic [7:0] char_code
);

	logic       valid_s1;
	logic [7:0] scan_byte_s1;
	flags_t     flags_q;
	flags_t     next_flags;
	logic [7:0] dec_char;
	logic       char_valid_q;
	logic [7:0] char_code_q;
	logic       advance;

	assign advance    = valid_s1 && (!char_valid_q || !char_stall);
	assign scan_stall = valid_s1 && !advance;
	assign char_valid = char_valid_q;
	assign char_code  = char_code_q;

	scs1_decode u_decode (
		.scan_byte  (scan_byte_s1),
		.flags      (flags_q),
		.next_flags (next_flags),
		.char_code  (dec_char)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!scan_stall) begin
			valid_s1 <= scan_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!scan_stall) begin
			scan_byte_s1 <= scan_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_q <= '0;
			char_valid_q <= 1'b0;
		end else if (advance) begin
			flags_q <= next_flags;
			char_valid_q <= 1'b1;
		end else if (!char_stall) begin
			char_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			char_code_q <= dec_char;
		end
	end

	a_prefix_gives_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && (scan_byte_s1 == SC_PREFIX)) |=> (char_valid && (char_code == KEY_NONE)
			&& flags_q.e0))
		else $error("prefix word did not give a zero char word");

	a_break_clears_prefix: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && scan_byte_s1[7] && (scan_byte_s1 != SC_PREFIX)) |=>
			(!flags_q.e0 && (char_code == KEY_NONE)))
		else $error("break word left prefix set or gave a char");

	a_flags_hold_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(flags_q))
		else $error("flags changed without a word moving through");

	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		scan_stall |-> (valid_s1 && char_valid && char_stall))
		else $error("input stalled while result path was free");

endmodule

// ===== tb/scancode_set1_to_ascii_tb.sv =====
module scancode_set1_to_ascii_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import scs1_pkg::*;

	class keymap_board;
		flags_t mods;
		logic [7:0] pending_chars[$];
		logic [7:0] plain_tab [0:87];
		logic [7:0] shift_tab [0:87];
		int unsigned mismatches;
		int unsigned checked;
		int unsigned nonzero;

		function new();
			mods = '0;
			mismatches = 0;
			checked = 0;
			nonzero = 0;
			plain_tab = '{
				8'h00, 8'h1B, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36,
				8'h37, 8'h38, 8'h39, 8'h30, 8'h2D, 8'h3D, 8'h08, 8'h09,
				8'h71, 8'h77, 8'h65, 8'h72, 8'h74, 8'h79, 8'h75, 8'h69,
				8'h6F, 8'h70, 8'h5B, 8'h5D, 8'h0A, 8'h00, 8'h61, 8'h73,
				8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B, 8'h6C, 8'h3B,
				8'h27, 8'h60, 8'h00, 8'h5C, 8'h7A, 8'h78, 8'h63, 8'h76,
				8'h62, 8'h6E, 8'h6D, 8'h2C, 8'h2E, 8'h2F, 8'h00, 8'h2A,
				8'h00, 8'h20, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
				8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h37,
				8'h38, 8'h39, 8'h2D, 8'h34, 8'h35, 8'h36, 8'h2B, 8'h31,
				8'h32, 8'h33, 8'h30, 8'h2E, 8'h00, 8'h00, 8'h00, 8'h00
			};
			shift_tab = '{
				8'h00, 8'h1B, 8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5E,
				8'h26, 8'h2A, 8'h28, 8'h29, 8'h5F, 8'h2B, 8'h08, 8'h09,
				8'h51, 8'h57, 8'h45, 8'h52, 8'h54, 8'h59, 8'h55, 8'h49,
				8'h4F, 8'h50, 8'h7B, 8'h7D, 8'h0A, 8'h00, 8'h41, 8'h53,
				8'h44, 8'h46, 8'h47, 8'h48, 8'h4A, 8'h4B, 8'h4C, 8'h3A,
				8'h22, 8'h7E, 8'h00, 8'h7C, 8'h5A, 8'h58, 8'h43, 8'h56,
				8'h42, 8'h4E, 8'h4D, 8'h3C, 8'h3E, 8'h3F, 8'h00, 8'h2A,
				8'h00, 8'h20, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
				8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h37,
				8'h38, 8'h39, 8'h2D, 8'h34, 8'h35, 8'h36, 8'h2B, 8'h31,
				8'h32, 8'h33, 8'h30, 8'h2E, 8'h00, 8'h00, 8'h00, 8'h00
			};
		endfunction

		function flags_t held_key_mask(logic [7:0] code);
			flags_t m;
			m = '0;
			m.ctrl = (code == SC_CTRL_MAKE) || (code == SC_CTRL_EXT);
			m.shift = (code == SC_LSHIFT) || (code == SC_RSHIFT);
			m.alt = (code == SC_ALT_MAKE) || (code == SC_ALT_EXT);
			return m;
		endfunction

		// Control characters follow from the plain letters, plus a few odd keys.
		function logic [7:0] ctrl_char(logic [7:0] code);
			logic [7:0] p;
			if (code >= CTRL_ROM_END) return KEY_NONE;
			p = plain_tab[code[6:0]];
			if (p >= 8'h61 && p <= 8'h7A) return p - 8'h60;
			if (p == 8'h5C) return 8'h1C;
			if (p == KEY_SLASH) return 8'hEF;
			if (code == 8'h1C) return 8'h0D;
			return KEY_NONE;
		endfunction

		function logic [7:0] key_char(logic [7:0] code);
			case (code)
				SC_KP_ENTER: return KEY_ENTER;
				SC_KP_DIVIDE: return KEY_SLASH;
				SC_HOME: return NAV_HOME;
				SC_END: return KEY_END;
				SC_UP: return KEY_UP;
				SC_DOWN: return KEY_DOWN;
				SC_LEFT: return KEY_LEFT;
				SC_RIGHT: return KEY_RIGHT;
				SC_PGUP: return NAV_PAGE_UP;
				SC_PGDN: return NAV_PAGE_DOWN;
				SC_INS: return KEY_INS;
				SC_DEL: return KEY_DEL;
				default: begin
				end
			endcase
			if (mods.ctrl) return ctrl_char(code);
			if (code >= MAIN_ROM_END) return KEY_NONE;
			if (mods.shift) return shift_tab[code[6:0]];
			return plain_tab[code[6:0]];
		endfunction

		function logic [7:0] translate_scan(logic [7:0] scan);
			logic [7:0] code;
			logic [7:0] c;
			code = scan;
			if (code == SC_PREFIX) begin
				mods.e0 = 1'b1;
				return KEY_NONE;
			end
			if (code[7]) begin
				if (!mods.e0) code[7] = 1'b0;
				mods = flags_t'(mods & ~held_key_mask(code));
				mods.e0 = 1'b0;
				return KEY_NONE;
			end
			if (mods.e0) begin
				code[7] = 1'b1;
				mods.e0 = 1'b0;
			end
			mods = flags_t'(mods | held_key_mask(code));
			if (code == SC_CAPS_LOCK) mods.caps = ~mods.caps;
			if (code == SC_NUM_LOCK) mods.num = ~mods.num;
			if (code == SC_SCROLL_LOCK) mods.scroll = ~mods.scroll;
			c = key_char(code);
			if (mods.caps && ((c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A)))
				c = c ^ CASE_FLIP;
			return c;
		endfunction

		function void note_scan(logic [7:0] scan);
			pending_chars.push_back(translate_scan(scan));
		endfunction

		function void check_char(logic [7:0] got);
			logic [7:0] want;
			if (pending_chars.size() == 0) begin
				$display("%0t: unexpected char word, expected none actual %h", $time, got);
				mismatches++;
				return;
			end
			want = pending_chars.pop_front();
			checked++;
			if (got != KEY_NONE) nonzero++;
			if (got !== want) begin
				$display("%0t: char_code expected %h actual %h", $time, want, got);
				mismatches++;
			end
		endfunction
	endclass

	localparam int RANDOM_WORDS = 1000;
	localparam logic [7:0] DIRECTED_WORDS [0:28] = '{
		8'h00, 8'hFF, 8'h7F, 8'h1E, SC_LSHIFT, 8'h1E, 8'hAA, SC_CTRL_MAKE, 8'h35,
		SC_CTRL_EXT, SC_CAPS_LOCK, SC_LSHIFT, 8'h1E, 8'hAA, SC_CAPS_LOCK,
		SC_PREFIX, 8'h47, SC_PREFIX, SC_PREFIX, 8'h48, SC_PREFIX, 8'hC8, 8'hE1,
		SC_ALT_MAKE, SC_ALT_EXT, SC_NUM_LOCK, SC_SCROLL_LOCK, SC_PREFIX, 8'h35
	};
	localparam logic [7:0] EXT_KEYS [0:11] = '{
		8'h1C, 8'h35, 8'h47, 8'h4F, 8'h48, 8'h50, 8'h4B, 8'h4D, 8'h49, 8'h51, 8'h52, 8'h53
	};
	localparam logic [7:0] MOD_KEYS [0:3] = '{SC_CTRL_MAKE, SC_LSHIFT, SC_RSHIFT, SC_ALT_MAKE};
	localparam logic [7:0] LOCK_KEYS [0:2] = '{SC_CAPS_LOCK, SC_NUM_LOCK, SC_SCROLL_LOCK};

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       scan_valid = 1'b0;
	logic       scan_stall;
	logic [7:0] scan_byte = 8'h00;
	logic       char_valid;
	logic       char_stall = 1'b0;
	logic [7:0] char_code;

	bit          quiet = 1'b0;
	int unsigned sent = 0;
	keymap_board board = new();

	scancode_set1_to_ascii i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.scan_valid(scan_valid),
		.scan_stall(scan_stall),
		.scan_byte(scan_byte),
		.char_valid(char_valid),
		.char_stall(char_stall),
		.char_code(char_code)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		char_stall <= !quiet && ($urandom_range(99) < 32);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (scan_valid && !scan_stall) board.note_scan(scan_byte);
			if (char_valid && !char_stall) board.check_char(char_code);
		end
	end

	task automatic send_scan(input logic [7:0] b);
		while (!quiet && $urandom_range(99) < 32) begin
			scan_valid <= 1'b0;
			@(posedge clk);
		end
		scan_valid <= 1'b1;
		scan_byte <= b;
		@(posedge clk);
		while (scan_stall) @(posedge clk);
		sent++;
	endtask

	task automatic tap_key(input logic [7:0] code, input bit ext, input bit lift);
		if (ext) send_scan(SC_PREFIX);
		send_scan(code);
		if (lift) begin
			if (ext) send_scan(SC_PREFIX);
			send_scan(code | SC_BREAK_BIT);
		end
	endtask

	initial begin
		logic [7:0] m;
		bit ext;
		int unsigned r;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (DIRECTED_WORDS[i]) send_scan(DIRECTED_WORDS[i]);
		// Mostly well-formed key strokes, with held modifiers and some raw noise.
		while (sent < RANDOM_WORDS + $size(DIRECTED_WORDS)) begin
			quiet = (sent >= 400) && (sent < 560);
			r = $urandom_range(99);
			if (r < 15) begin
				m = MOD_KEYS[$urandom_range(3)];
				ext = ((m == SC_CTRL_MAKE) || (m == SC_ALT_MAKE)) && $urandom_range(1);
				if ($urandom_range(1)) begin
					tap_key(m, ext, 1'b0);
				end else begin
					if (ext) send_scan(SC_PREFIX);
					send_scan(m | SC_BREAK_BIT);
				end
			end else if (r < 22) begin
				tap_key(LOCK_KEYS[$urandom_range(2)], 1'b0, 1'b1);
			end else if (r < 35) begin
				tap_key(EXT_KEYS[$urandom_range(11)], 1'b1, 1'($urandom_range(1)));
			end else if (r < 85) begin
				tap_key(8'($urandom_range(8'h57)), 1'b0, $urandom_range(3) != 0);
			end else begin
				send_scan(8'($urandom_range(255)));
			end
		end
		quiet = 1'b0;
		scan_valid <= 1'b0;
		while (board.pending_chars.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (board.pending_chars.size() != 0) begin
			$display("%0t: %0d char words never arrived", $time, board.pending_chars.size());
			board.mismatches++;
		end
		$display("Sent %0d scan words: key strokes, modifiers, locks, prefixed keys and noise.",
			sent);
		$display("Checked %0d char words, %0d of them nonzero.", board.checked, board.nonzero);
		if (board.mismatches == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

	initial begin
		#2_000_000;
		$display("Run timed out.");
		$display("end of test: mismatches");
		$finish;
	end

endmodule

// ===== sim.f =====
hw/rtl/scs1_pkg.sv
hw/rtl/scs1_decode.sv
hw/rtl/scancode_set1_to_ascii.sv
tb/scancode_set1_to_ascii_tb.sv
